FILE: sv/gpe_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control structs of the gate position estimator.
package gpe_pkg;

	localparam int POSITION_BITS_DEF = 16;

	localparam int TIME_W     = 32;
	localparam int DUR_W      = 20;
	localparam int PUB_W      = 16;
	localparam int OP_W       = 2;
	localparam int ST_W       = 3;
	localparam int MV_W       = 2;
	localparam int ACT_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [DUR_W-1:0] DUR_MAX   = 20'd600000;
	localparam logic [DUR_W-1:0] DUR_RESET = 20'd20000;
	localparam logic [PUB_W-1:0] PUB_RESET = 16'd250;

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_STATUS = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP   = 2'd2;
	localparam logic [OP_W-1:0] OP_POS    = 2'd3;

	localparam logic [ST_W-1:0] ST_CLOSED  = 3'd0;
	localparam logic [ST_W-1:0] ST_OPENING = 3'd1;
	localparam logic [ST_W-1:0] ST_OPENED  = 3'd2;
	localparam logic [ST_W-1:0] ST_CLOSING = 3'd3;
	localparam logic [ST_W-1:0] ST_PAUSED  = 3'd4;
	localparam logic [ST_W-1:0] ST_OTHER   = 3'd5;

	localparam logic [MV_W-1:0] MV_IDLE    = 2'd0;
	localparam logic [MV_W-1:0] MV_OPENING = 2'd1;
	localparam logic [MV_W-1:0] MV_CLOSING = 2'd2;

	localparam logic [ACT_W-1:0] ACT_OPEN = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STOP = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_MS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH   = 2'd3;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic commit;
	} gpe_cmd_t;

	typedef struct packed {
		logic tick_moving;
		logic slot_free;
	} gpe_sts_t;

endpackage

FILE: sv/gpe_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the gate position estimator.
interface gpe_in_if #(parameter int POSITION_BITS = gpe_pkg::POSITION_BITS_DEF);
	logic                        valid;
	logic                        ready;
	logic [gpe_pkg::OP_W-1:0]    operation;
	logic [gpe_pkg::TIME_W-1:0]  now_ms;
	logic [gpe_pkg::ST_W-1:0]    gate_status;
	logic [POSITION_BITS-1:0]    target_position;

	modport source (output valid, operation, now_ms, gate_status, target_position,
		input ready);
	modport sink (input valid, operation, now_ms, gate_status, target_position,
		output ready);
endinterface

interface gpe_out_if #(parameter int POSITION_BITS = gpe_pkg::POSITION_BITS_DEF);
	logic                        valid;
	logic                        ready;
	logic                        action_valid;
	logic [gpe_pkg::ACT_W-1:0]   action;
	logic [POSITION_BITS-1:0]    position_out;
	logic [gpe_pkg::MV_W-1:0]    motion;
	logic                        publish;
	logic [gpe_pkg::DUR_W-1:0]   learned_open_ms;
	logic [gpe_pkg::DUR_W-1:0]   learned_close_ms;

	modport source (output valid, action_valid, action, position_out, motion, publish,
		learned_open_ms, learned_close_ms, input ready);
	modport sink (input valid, action_valid, action, position_out, motion, publish,
		learned_open_ms, learned_close_ms, output ready);
endinterface

FILE: sv/gpe_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: request intake, divider sequencing and result commit.
module gpe_ctrl #(
	parameter int POSITION_BITS = gpe_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gpe_pkg::gpe_sts_t sts,
	output gpe_pkg::gpe_cmd_t cmd
);
	import gpe_pkg::*;

	localparam int CNT_W = $clog2(POSITION_BITS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.tick_moving ? S_DIV : S_FIN;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.prep) begin
				cnt_q <= CNT_W'(POSITION_BITS);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q != '0)
		else $error("divider sequenced with empty bit count");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.slot_free)
		else $error("result committed over an undelivered result");

	a_load_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_PREP)
		else $error("accepted request not followed by prepare step");

endmodule

FILE: sv/gpe_datapath.sv
`timescale 1ns / 1ps
// Datapath: estimator state, config registers, restoring divider and result register.
module gpe_datapath #(
	parameter int POSITION_BITS = gpe_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gpe_pkg::gpe_cmd_t                 cmd,
	output gpe_pkg::gpe_sts_t                 sts,
	input  logic [gpe_pkg::OP_W-1:0]          operation,
	input  logic [gpe_pkg::TIME_W-1:0]        now_ms,
	input  logic [gpe_pkg::ST_W-1:0]          gate_status,
	input  logic [POSITION_BITS-1:0]          target_position,
	input  logic                              cfg_we,
	input  logic [gpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gpe_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic                              action_valid,
	output logic [gpe_pkg::ACT_W-1:0]         action,
	output logic [POSITION_BITS-1:0]          position_out,
	output logic [gpe_pkg::MV_W-1:0]          motion,
	output logic                              publish,
	output logic [gpe_pkg::DUR_W-1:0]         learned_open_ms,
	output logic [gpe_pkg::DUR_W-1:0]         learned_close_ms
);
	import gpe_pkg::*;

	localparam int NUM_W = TIME_W + POSITION_BITS;
	localparam logic [POSITION_BITS-1:0] FULL = '1;

	function automatic logic [DUR_W-1:0] sat_duration(input logic [TIME_W-1:0] v);
		logic [DUR_W-1:0] r;
		if (v == '0) begin
			r = DUR_W'(1);
		end else if (v > TIME_W'(DUR_MAX)) begin
			r = DUR_MAX;
		end else begin
			r = v[DUR_W-1:0];
		end
		return r;
	endfunction

	// latched request
	logic [OP_W-1:0]          op_q;
	logic [TIME_W-1:0]        now_q;
	logic [ST_W-1:0]          st_q;
	logic [POSITION_BITS-1:0] tgt_q;

	// estimator state
	logic [POSITION_BITS-1:0] pos_q;
	logic [ST_W-1:0]          last_st_q;
	logic [MV_W-1:0]          mv_q;
	logic [POSITION_BITS-1:0] goal_q;
	logic                     goal_valid_q;
	logic [TIME_W-1:0]        last_rc_q;
	logic [TIME_W-1:0]        last_pub_q;
	logic [TIME_W-1:0]        cstart_q;
	logic                     cstart_valid_q;
	logic [DUR_W-1:0]         open_q;
	logic [DUR_W-1:0]         close_q;
	logic                     learn_q;
	logic [PUB_W-1:0]         pub_iv_q;

	// divider
	logic                     sat_q;
	logic [DUR_W-1:0]         rem_q;
	logic [POSITION_BITS-1:0] low_q;
	logic [POSITION_BITS-1:0] quo_q;

	// result register
	logic                     out_valid_q;
	logic                     act_valid_q;
	logic [ACT_W-1:0]         act_q;
	logic [POSITION_BITS-1:0] pos_out_q;
	logic [MV_W-1:0]          mv_out_q;
	logic                     pub_q;
	logic [DUR_W-1:0]         open_out_q;
	logic [DUR_W-1:0]         close_out_q;

	logic [DUR_W-1:0]         dur;
	logic [TIME_W-1:0]        elapsed;
	logic [NUM_W-1:0]         num;
	logic [TIME_W-1:0]        num_hi;
	logic [DUR_W:0]           trial;
	logic                     trial_ge;

	logic [TIME_W-1:0]        since_pub;
	logic [TIME_W-1:0]        cycle_time;
	logic [POSITION_BITS-1:0] room;

	logic [POSITION_BITS-1:0] pos_n;
	logic [ST_W-1:0]          last_st_n;
	logic [MV_W-1:0]          mv_n;
	logic [POSITION_BITS-1:0] goal_n;
	logic                     goal_valid_n;
	logic [TIME_W-1:0]        last_rc_n;
	logic [TIME_W-1:0]        last_pub_n;
	logic [TIME_W-1:0]        cstart_n;
	logic                     cstart_valid_n;
	logic [DUR_W-1:0]         open_n;
	logic [DUR_W-1:0]         close_n;
	logic                     act_valid_n;
	logic [ACT_W-1:0]         act_n;
	logic                     pub_n;

	assign sts.tick_moving = (op_q == OP_TICK) && (mv_q != MV_IDLE);
	assign sts.slot_free   = !out_valid_q || out_ready;

	// step = (elapsed * FULL + dur/2) / dur, FULL * x taken as (x << bits) - x
	assign dur      = (mv_q == MV_CLOSING) ? close_q : open_q;
	assign elapsed  = now_q - last_rc_q;
	assign num      = {elapsed, {POSITION_BITS{1'b0}}} - NUM_W'(elapsed)
		+ NUM_W'(dur >> 1);
	assign num_hi   = num[NUM_W-1:POSITION_BITS];
	assign trial    = {rem_q, low_q[POSITION_BITS-1]};
	assign trial_ge = trial >= {1'b0, dur};

	assign since_pub  = now_q - last_pub_q;
	assign cycle_time = now_q - cstart_q;
	assign room       = FULL - pos_q;

	always_comb begin
		pos_n          = pos_q;
		last_st_n      = last_st_q;
		mv_n           = mv_q;
		goal_n         = goal_q;
		goal_valid_n   = goal_valid_q;
		last_rc_n      = last_rc_q;
		last_pub_n     = last_pub_q;
		cstart_n       = cstart_q;
		cstart_valid_n = cstart_valid_q;
		open_n         = open_q;
		close_n        = close_q;
		act_valid_n    = 1'b0;
		act_n          = ACT_OPEN;
		pub_n          = 1'b0;
		unique case (op_q)
			OP_TICK: begin
				if (mv_q != MV_IDLE) begin
					if (mv_q == MV_CLOSING) begin
						pos_n = (sat_q || quo_q >= pos_q) ? '0 : pos_q - quo_q;
					end else begin
						pos_n = (sat_q || quo_q >= room) ? FULL : pos_q + quo_q;
					end
					last_rc_n = now_q;
					if (since_pub >= TIME_W'(pub_iv_q)) begin
						pub_n      = 1'b1;
						last_pub_n = now_q;
					end
					if (goal_valid_q && !(mv_q == MV_OPENING && pos_n < goal_q)
						&& !(mv_q == MV_CLOSING && pos_n > goal_q)) begin
						act_valid_n  = 1'b1;
						act_n        = ACT_STOP;
						goal_valid_n = 1'b0;
					end
				end
			end
			OP_STATUS: begin
				if (st_q != last_st_q) begin
					if (learn_q) begin
						if (st_q == ST_PAUSED) begin
							cstart_valid_n = 1'b0;
						end else if ((last_st_q == ST_CLOSED && st_q == ST_OPENING)
							|| (last_st_q == ST_OPENED && st_q == ST_CLOSING)) begin
							cstart_n       = now_q;
							cstart_valid_n = 1'b1;
						end else if (cstart_valid_q) begin
							if (st_q == ST_OPENED) begin
								open_n = sat_duration(cycle_time);
							end
							if (st_q == ST_CLOSED) begin
								close_n = sat_duration(cycle_time);
							end
							cstart_valid_n = 1'b0;
						end
					end
					if (st_q == ST_OPENED) begin
						act_valid_n = 1'b1;
						act_n       = ACT_STOP;
						pos_n       = FULL;
					end else if (st_q == ST_CLOSED) begin
						pos_n = '0;
					end
					last_st_n  = st_q;
					mv_n       = (st_q == ST_OPENING) ? MV_OPENING :
						(st_q == ST_CLOSING) ? MV_CLOSING : MV_IDLE;
					pub_n      = 1'b1;
					last_pub_n = now_q;
					last_rc_n  = now_q;
				end
			end
			OP_STOP: begin
				act_valid_n = 1'b1;
				act_n       = ACT_STOP;
			end
			OP_POS: begin
				if (tgt_q != pos_q) begin
					act_valid_n = 1'b1;
					if (tgt_q == FULL) begin
						act_n = ACT_OPEN;
					end else if (tgt_q == '0) begin
						act_n = ACT_STOP;
					end else begin
						goal_n       = tgt_q;
						goal_valid_n = 1'b1;
						act_n        = (tgt_q > pos_q) ? ACT_OPEN : ACT_STOP;
					end
				end
			end
			default: act_n = ACT_OPEN;
		endcase
	end

	// request latch, divider and payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			now_q <= now_ms;
			st_q  <= (gate_status > ST_OTHER) ? ST_OTHER : gate_status;
			tgt_q <= target_position;
		end
		if (cmd.prep) begin
			sat_q <= num_hi >= TIME_W'(dur);
			rem_q <= num_hi[DUR_W-1:0];
			low_q <= num[POSITION_BITS-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? DUR_W'(trial - {1'b0, dur}) : trial[DUR_W-1:0];
			low_q <= {low_q[POSITION_BITS-2:0], 1'b0};
			quo_q <= {quo_q[POSITION_BITS-2:0], trial_ge};
		end
		if (cmd.commit) begin
			goal_q      <= goal_n;
			cstart_q    <= cstart_n;
			act_valid_q <= act_valid_n;
			act_q       <= act_n;
			pos_out_q   <= pos_n;
			mv_out_q    <= mv_n;
			pub_q       <= pub_n;
			open_out_q  <= open_n;
			close_out_q <= close_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			last_st_q      <= ST_OTHER;
			mv_q           <= MV_IDLE;
			goal_valid_q   <= 1'b0;
			last_rc_q      <= '0;
			last_pub_q     <= '0;
			cstart_valid_q <= 1'b0;
			open_q         <= DUR_RESET;
			close_q        <= DUR_RESET;
			learn_q        <= 1'b0;
			pub_iv_q       <= PUB_RESET;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LEARN:    learn_q  <= cfg_data[0];
					CFG_OPEN_MS:  open_q   <= sat_duration(TIME_W'(cfg_data));
					CFG_CLOSE_MS: close_q  <= sat_duration(TIME_W'(cfg_data));
					CFG_PUBLISH:  pub_iv_q <= cfg_data[PUB_W-1:0];
					default:      learn_q  <= learn_q;
				endcase
			end else if (cmd.commit) begin
				pos_q          <= pos_n;
				last_st_q      <= last_st_n;
				mv_q           <= mv_n;
				goal_valid_q   <= goal_valid_n;
				last_rc_q      <= last_rc_n;
				last_pub_q     <= last_pub_n;
				cstart_valid_q <= cstart_valid_n;
				open_q         <= open_n;
				close_q        <= close_n;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign action_valid     = act_valid_q;
	assign action           = act_q;
	assign position_out     = pos_out_q;
	assign motion           = mv_out_q;
	assign publish          = pub_q;
	assign learned_open_ms  = open_out_q;
	assign learned_close_ms = close_out_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (sat_q || rem_q < dur))
		else $error("divider remainder not below duration");

	a_dur_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		open_q != '0 && close_q != '0 && open_q <= DUR_MAX && close_q <= DUR_MAX)
		else $error("duration out of range");

	a_goal_partial: assert property (@(posedge clk) disable iff (!arst_n)
		goal_valid_q |-> (goal_q != '0 && goal_q != FULL))
		else $error("goal set at an end position");

endmodule

FILE: sv/gate_position_estimator.sv
`timescale 1ns / 1ps
// Gate position estimator top level: controller, datapath and channel wiring.
// Flow: a request is taken in the idle state and latched, a prepare step follows, then for a tick
// while the gate moves the restoring divider steps, and a commit step writes the result register.
// One request at a time: the next is taken only after the commit step. The restoring divider
// makes one quotient bit per cycle; every other request skips the divider steps.
// A waiting result does not block the next request until its commit step.
// Reset (arst_n low) clears control state, position, motion and timers at once.
module gate_position_estimator #(
	parameter int POSITION_BITS = gpe_pkg::POSITION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	gpe_in_if.sink                         in_ch,
	gpe_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [gpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gpe_pkg::*;

	gpe_cmd_t cmd;
	gpe_sts_t sts;

	gpe_ctrl #(
		.POSITION_BITS(POSITION_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gpe_datapath #(
		.POSITION_BITS(POSITION_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.operation        (in_ch.operation),
		.now_ms           (in_ch.now_ms),
		.gate_status      (in_ch.gate_status),
		.target_position  (in_ch.target_position),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_ready        (out_ch.ready),
		.out_valid        (out_ch.valid),
		.action_valid     (out_ch.action_valid),
		.action           (out_ch.action),
		.position_out     (out_ch.position_out),
		.motion           (out_ch.motion),
		.publish          (out_ch.publish),
		.learned_open_ms  (out_ch.learned_open_ms),
		.learned_close_ms (out_ch.learned_close_ms)
	);

endmodule
